>>> sv/owpm_pkg.sv
// Package for the three-wheel omni PWM mixer: register indexes, fixed-point
// constants and field widths. No dependencies.
`default_nettype none

package owpm_pkg;

    localparam int NUM_WHEELS = 3;
    localparam int FIELD_W    = 16;
    localparam int PROD_W     = 2 * FIELD_W;
    // sum of three signed products
    localparam int SUM_W      = PROD_W + 2;
    localparam int ACC_SHIFT  = 11;
    localparam int DUTY_W     = SUM_W - ACC_SHIFT;
    // magnitude of a clamped duty, 0..25600
    localparam int MAG_W      = 15;
    localparam int SCALED_W   = MAG_W + FIELD_W;

    // full-scale duty, 100 percent in Q8
    localparam logic signed [DUTY_W-1:0] DUTY_POS = DUTY_W'(25600);
    localparam logic signed [DUTY_W-1:0] DUTY_NEG = -DUTY_W'(25600);
    localparam logic [MAG_W-1:0]         MAG_FULL = MAG_W'(25600);

    // 25600 = 1024 * 25: drop 10 bits, then divide by 25 through a reciprocal
    localparam int DIV_DROP   = 10;
    localparam int QUOT_IN_W  = SCALED_W - DIV_DROP;
    localparam int RECIP_SH   = 26;
    localparam int RECIP_W    = 22;
    localparam logic [RECIP_W-1:0] RECIP25 = RECIP_W'(2684355);
    localparam int SPLIT      = 11;
    localparam int PART_LO_W  = SPLIT + RECIP_W;
    localparam int PART_HI_W  = (QUOT_IN_W - SPLIT) + RECIP_W;
    localparam int RSUM_W     = QUOT_IN_W + RECIP_W;
    localparam int QUOT_W     = RSUM_W - RECIP_SH;

    localparam logic [FIELD_W-1:0] RELOAD_RESET = 16'hFFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_X1  = 3'd0,
        REG_COEF_Y1  = 3'd1,
        REG_COEF_X2  = 3'd2,
        REG_COEF_Y2  = 3'd3,
        REG_COEF_X3  = 3'd4,
        REG_COEF_Y3  = 3'd5,
        REG_COEF_ROT = 3'd6,
        REG_RELOAD   = 3'd7
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> sv/omni_wheel_pwm_mixer.sv
// Top level of the three-wheel omni PWM mixer: config registers and a
// five-stage pipeline from velocity command to per-wheel PWM compare.
// Depends on owpm_pkg.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   seven Q4.11 coefficients and the PWM reload; cfg_ready is always high.
//   Write only while no command is in flight.
//   Input stream carries one velocity command per beat (vx, vy, omega, Q8.8).
//   Output stream carries one beat per command: three compare values and
//   three direction bits.
//   A command passes through the registered stages in order (products, sum
//   and clamp, reload scaling, two-part reciprocal divide, output); one
//   command per cycle is sustained while the receiver does not stall.
//   When the receiver stalls, the whole pipeline holds and s_axis_tready
//   drops while the output register is full; nothing is lost or repeated.
//   Reset clears all valid bits, sets the coefficients to zero and the
//   reload to full scale.
`default_nettype none

module omni_wheel_pwm_mixer
    import owpm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [FIELD_W-1:0]    cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: vel_x[15:0], vel_y[31:16], rate_omega[47:32]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // tdata: compare_wheel1[15:0], compare_wheel2[31:16], compare_wheel3[47:32],
    //        forward_wheel1[48], forward_wheel2[49], forward_wheel3[50], zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // config registers
    logic signed [FIELD_W-1:0] coef_x_reg [NUM_WHEELS];
    logic signed [FIELD_W-1:0] coef_y_reg [NUM_WHEELS];
    logic signed [FIELD_W-1:0] coef_rot_reg;
    logic        [FIELD_W-1:0] reload_reg;

    // pipeline control
    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    // stage 1: products
    logic signed [PROD_W-1:0] prod_x_reg [NUM_WHEELS];
    logic signed [PROD_W-1:0] prod_y_reg [NUM_WHEELS];
    logic signed [PROD_W-1:0] prod_w_reg;

    // stage 2: clamped duty magnitude and direction
    logic [MAG_W-1:0] mag_next [NUM_WHEELS];
    logic [MAG_W-1:0] mag_reg  [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] fwd_next, fwd2_reg, fwd3_reg, fwd4_reg, fwd_out_reg;

    // stage 3: magnitude scaled by reload, low bits dropped
    logic [QUOT_IN_W-1:0] qin_reg [NUM_WHEELS];

    // stage 4: reciprocal partial products
    logic [PART_LO_W-1:0] plo_reg [NUM_WHEELS];
    logic [PART_HI_W-1:0] phi_reg [NUM_WHEELS];

    // stage 5: output compare values
    logic [FIELD_W-1:0] cmp_next [NUM_WHEELS];
    logic [FIELD_W-1:0] cmp_reg  [NUM_WHEELS];

    // config port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                coef_x_reg[i] <= '0;
                coef_y_reg[i] <= '0;
            end
            coef_rot_reg <= '0;
            reload_reg   <= RELOAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COEF_X1:  coef_x_reg[0] <= cfg_data;
                REG_COEF_Y1:  coef_y_reg[0] <= cfg_data;
                REG_COEF_X2:  coef_x_reg[1] <= cfg_data;
                REG_COEF_Y2:  coef_y_reg[1] <= cfg_data;
                REG_COEF_X3:  coef_x_reg[2] <= cfg_data;
                REG_COEF_Y3:  coef_y_reg[2] <= cfg_data;
                REG_COEF_ROT: coef_rot_reg  <= cfg_data;
                REG_RELOAD:   reload_reg    <= cfg_data;
                default:      reload_reg    <= reload_reg;
            endcase
        end
    end

    // whole pipeline moves unless the output register is full and stalled
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= s_axis_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // stage 1: seven 16x16 signed multiplies, rotation term shared
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                prod_x_reg[i] <= PROD_W'($signed(s_axis_tdata[15:0]))
                                 * PROD_W'(coef_x_reg[i]);
                prod_y_reg[i] <= PROD_W'($signed(s_axis_tdata[31:16]))
                                 * PROD_W'(coef_y_reg[i]);
            end
            prod_w_reg <= PROD_W'($signed(s_axis_tdata[47:32])) * PROD_W'(coef_rot_reg);
        end
    end

    // stage 2: sum, floor shift, clamp to +/-100 percent, magnitude
    always_comb
    begin
        logic signed [SUM_W-1:0]  sum;
        logic signed [DUTY_W-1:0] duty;
        logic signed [DUTY_W-1:0] neg_duty;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            sum = SUM_W'(prod_x_reg[i]) + SUM_W'(prod_y_reg[i]) + SUM_W'(prod_w_reg);
            duty     = sum[SUM_W-1:ACC_SHIFT];
            neg_duty = -duty;
            if (duty > DUTY_POS)
            begin
                mag_next[i] = MAG_FULL;
                fwd_next[i] = 1'b1;
            end
            else if (duty < DUTY_NEG)
            begin
                mag_next[i] = MAG_FULL;
                fwd_next[i] = 1'b0;
            end
            else if (duty[DUTY_W-1])
            begin
                mag_next[i] = neg_duty[MAG_W-1:0];
                fwd_next[i] = 1'b0;
            end
            else
            begin
                mag_next[i] = duty[MAG_W-1:0];
                fwd_next[i] = 1'b1;
            end
        end
    end

    // stages 2 to 4: magnitude times reload, then reciprocal partial products
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd2_reg <= fwd_next;
            fwd3_reg <= fwd2_reg;
            fwd4_reg <= fwd3_reg;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                mag_reg[i] <= mag_next[i];
                qin_reg[i] <= QUOT_IN_W'((SCALED_W'(mag_reg[i]) * SCALED_W'(reload_reg))
                                         >> DIV_DROP);
                plo_reg[i] <= PART_LO_W'(qin_reg[i][SPLIT-1:0]) * PART_LO_W'(RECIP25);
                phi_reg[i] <= PART_HI_W'(qin_reg[i][QUOT_IN_W-1:SPLIT])
                              * PART_HI_W'(RECIP25);
            end
        end
    end

    // stage 5: combine partials, quotient by 25, cap at reload
    always_comb
    begin
        logic [RSUM_W-1:0] rsum;
        logic [QUOT_W-1:0] quot;
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            rsum = (RSUM_W'(phi_reg[i]) << SPLIT) + RSUM_W'(plo_reg[i]);
            quot = rsum[RSUM_W-1:RECIP_SH];
            if (quot > QUOT_W'(reload_reg))
                cmp_next[i] = reload_reg;
            else
                cmp_next[i] = quot[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_out_reg <= fwd4_reg;
            for (int i = 0; i < NUM_WHEELS; i++)
                cmp_reg[i] <= cmp_next[i];
        end
    end

    // output beat
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, fwd_out_reg, cmp_reg[2], cmp_reg[1], cmp_reg[0]};

endmodule

`default_nettype wire

>>> dv/tb_omni_wheel_pwm_mixer.sv
// Self-checking testbench for omni_wheel_pwm_mixer: a directed table, then
// random commands under several register settings, all checked beat by beat.
// Depends on owpm_pkg and the mixer RTL.
`timescale 1ns / 1ps

module tb_omni_wheel_pwm_mixer;

    import owpm_pkg::*;

    localparam longint DUTY_FULL      = 25600;
    localparam int     MAX_WAIT       = 17;
    localparam int     NUM_PHASES     = 7;
    localparam int     ITEMS_PER_PHASE = 200;
    localparam int     TAIL_CYCLES    = 20;
    // well above sender gap + receiver stall + pipeline depth
    localparam int     WATCHDOG_LIMIT = 500;

    // one result beat: compare values and direction bits, index 0 is wheel 1
    typedef struct packed {
        logic [NUM_WHEELS-1:0]              fwd;
        logic [NUM_WHEELS-1:0][FIELD_W-1:0] cmp;
    } mix_t;

    typedef enum bit {ROW_WRITE, ROW_CMD} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        cfg_reg_t           reg_idx;
        logic [FIELD_W-1:0] wdata;
        logic [FIELD_W-1:0] vx;
        logic [FIELD_W-1:0] vy;
        logic [FIELD_W-1:0] wz;
        bit                 has_want;
        mix_t               want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [FIELD_W-1:0]    cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: vel_x[15:0], vel_y[31:16], rate_omega[47:32]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: compare_wheel1..3 [47:0], forward_wheel1..3 [50:48], zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // shadow copy of the register file
    logic signed [FIELD_W-1:0] coef_x [NUM_WHEELS];
    logic signed [FIELD_W-1:0] coef_y [NUM_WHEELS];
    logic signed [FIELD_W-1:0] coef_rot;
    logic [FIELD_W-1:0]        reload;

    mix_t      expected_mix_q[$];
    stim_row_t directed_rows[$];
    int        mismatch_count;
    bit        sender_burst;
    bit        sink_burst;
    mix_t      got_mix;
    mix_t      want_mix;

    omni_wheel_pwm_mixer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // duty per wheel: floor of the Q.19 sum by 2^11, clamped, scaled to reload
    function automatic mix_t mix_wheels(logic signed [FIELD_W-1:0] vx,
                                        logic signed [FIELD_W-1:0] vy,
                                        logic signed [FIELD_W-1:0] wz);
        mix_t   r;
        longint acc;
        longint duty;
        longint mag;
        int     i;
        for (i = 0; i < NUM_WHEELS; i++)
        begin
            acc = longint'(vx) * longint'(coef_x[i]) + longint'(vy) * longint'(coef_y[i])
                  + longint'(wz) * longint'(coef_rot);
            duty = acc >>> ACC_SHIFT;
            if (duty > DUTY_FULL)
                duty = DUTY_FULL;
            if (duty < -DUTY_FULL)
                duty = -DUTY_FULL;
            r.fwd[i] = (duty >= 0);
            mag = (duty < 0) ? -duty : duty;
            mag = mag * longint'(reload) / DUTY_FULL;
            if (mag > longint'(reload))
                mag = longint'(reload);
            r.cmp[i] = mag[FIELD_W-1:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // table building
    function automatic void add_write(cfg_reg_t idx, logic [FIELD_W-1:0] v);
        stim_row_t row;
        row.kind     = ROW_WRITE;
        row.reg_idx  = idx;
        row.wdata    = v;
        row.vx       = '0;
        row.vy       = '0;
        row.wz       = '0;
        row.has_want = 1'b0;
        row.want     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cmd(logic [FIELD_W-1:0] vx, logic [FIELD_W-1:0] vy,
                                    logic [FIELD_W-1:0] wz);
        stim_row_t row;
        row.kind     = ROW_CMD;
        row.reg_idx  = REG_COEF_X1;
        row.wdata    = '0;
        row.vx       = vx;
        row.vy       = vy;
        row.wz       = wz;
        row.has_want = 1'b0;
        row.want     = '0;
        directed_rows.push_back(row);
    endfunction

    // fwd bits are {wheel3, wheel2, wheel1}
    function automatic void add_cmd_known(logic [FIELD_W-1:0] vx, logic [FIELD_W-1:0] vy,
                                          logic [FIELD_W-1:0] wz, logic [FIELD_W-1:0] c1,
                                          logic [FIELD_W-1:0] c2, logic [FIELD_W-1:0] c3,
                                          logic [NUM_WHEELS-1:0] f);
        add_cmd(vx, vy, wz);
        directed_rows[$].has_want = 1'b1;
        directed_rows[$].want.cmp[0] = c1;
        directed_rows[$].want.cmp[1] = c2;
        directed_rows[$].want.cmp[2] = c3;
        directed_rows[$].want.fwd    = f;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_vel();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return FIELD_W'($urandom);
        else if (pick < 8)
            return FIELD_W'($urandom_range(0, 600) - 300);
        else if (pick == 8)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return FIELD_W'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_coef();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return FIELD_W'($urandom);
        else if (pick < 7)
            return FIELD_W'($urandom_range(0, 4096) - 2048);
        else if (pick == 7)
            return FIELD_W'($urandom_range(0, 128) - 64);
        else if (pick == 8)
            return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
        return 16'h0000;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_reload();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd25600;
            3:       return 16'd1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // config write, only called with nothing in flight
    task automatic write_reg(cfg_reg_t idx, logic [FIELD_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            REG_COEF_X1:  coef_x[0] = v;
            REG_COEF_Y1:  coef_y[0] = v;
            REG_COEF_X2:  coef_x[1] = v;
            REG_COEF_Y2:  coef_y[1] = v;
            REG_COEF_X3:  coef_x[2] = v;
            REG_COEF_Y3:  coef_y[2] = v;
            REG_COEF_ROT: coef_rot  = v;
            default:      reload    = v;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one command beat; the expectation is queued at acceptance
    task automatic send_cmd(logic [FIELD_W-1:0] vx, logic [FIELD_W-1:0] vy,
                            logic [FIELD_W-1:0] wz, bit has_want, mix_t want);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wz, vy, vx};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        expected_mix_q.push_back(has_want ? want : mix_wheels(vx, vy, wz));
    endtask

    // stop sending and wait until every expected beat has come out
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_mix_q.size() != 0)
            @(posedge clk);
    endtask

    // result sink with random stalls
    initial
    begin : sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // compare each output beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_mix_q.size() == 0)
                flag_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
            else
            begin
                want_mix = expected_mix_q.pop_front();
                got_mix.cmp = m_axis_tdata[NUM_WHEELS*FIELD_W-1:0];
                got_mix.fwd = m_axis_tdata[NUM_WHEELS*FIELD_W +: NUM_WHEELS];
                for (int w = 0; w < NUM_WHEELS; w++)
                begin
                    if (got_mix.cmp[w] !== want_mix.cmp[w])
                        flag_mismatch($sformatf("compare_wheel%0d got %0d want %0d",
                                                w + 1, got_mix.cmp[w], want_mix.cmp[w]));
                    if (got_mix.fwd[w] !== want_mix.fwd[w])
                        flag_mismatch($sformatf("forward_wheel%0d got %b want %b",
                                                w + 1, got_mix.fwd[w], want_mix.fwd[w]));
                end
            end
        end
    end

    // watchdog: too many cycles with no beat on any channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : main
        int p;
        int k;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        mismatch_count = 0;
        sender_burst   = 1'b0;
        sink_burst     = 1'b0;
        for (k = 0; k < NUM_WHEELS; k++)
        begin
            coef_x[k] = '0;
            coef_y[k] = '0;
        end
        coef_rot = '0;
        reload   = RELOAD_RESET;

        // after reset every coefficient is zero: all wheels forward, compare 0
        add_cmd_known(0, 0, 0, 0, 0, 0, 3'b111);
        add_cmd_known(32767, -32768, 32767, 0, 0, 0, 3'b111);
        add_cmd_known(-32768, -32768, -32768, 0, 0, 0, 3'b111);
        // unit gains: wheel1 = vx, wheel2 = vy, wheel3 = -vx, reload = full duty
        add_write(REG_COEF_X1, 2048);
        add_write(REG_COEF_Y1, 0);
        add_write(REG_COEF_X2, 0);
        add_write(REG_COEF_Y2, 2048);
        add_write(REG_COEF_X3, -2048);
        add_write(REG_COEF_Y3, 0);
        add_write(REG_COEF_ROT, 0);
        add_write(REG_RELOAD, 25600);
        add_cmd_known(25600, 0, 0, 25600, 0, 25600, 3'b011);
        add_cmd_known(32767, -32768, 0, 25600, 25600, 25600, 3'b001);
        add_cmd_known(-32768, 32767, 0, 25600, 25600, 25600, 3'b110);
        add_cmd_known(256, -256, 0, 256, 256, 256, 3'b001);
        add_cmd_known(0, 0, 32767, 0, 0, 0, 3'b111);
        // tiny negative sums floor to a duty of -1: reverse
        add_write(REG_COEF_X1, 1);
        add_cmd_known(-1, 0, 0, 1, 0, 1, 3'b110);
        add_cmd_known(-2047, 0, 0, 1, 0, 2047, 3'b110);
        add_cmd(2047, 3, -5);
        // rotation term saturates every wheel
        add_write(REG_COEF_ROT, 32767);
        add_write(REG_RELOAD, 16'hFFFF);
        add_cmd_known(0, 0, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000);
        add_cmd_known(0, 0, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
        add_cmd(1000, -2000, 300);
        // zero reload
        add_write(REG_RELOAD, 0);
        add_cmd_known(0, 0, -32768, 0, 0, 0, 3'b000);
        add_cmd(12345, -777, -4000);
        // most negative coefficients everywhere
        add_write(REG_COEF_X1, 16'h8000);
        add_write(REG_COEF_Y1, 16'h8000);
        add_write(REG_COEF_X2, 16'h8000);
        add_write(REG_COEF_Y2, 16'h8000);
        add_write(REG_COEF_X3, 16'h8000);
        add_write(REG_COEF_Y3, 16'h8000);
        add_write(REG_COEF_ROT, 16'h8000);
        add_write(REG_RELOAD, 16'hFFFF);
        add_cmd_known(-32768, -32768, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
        add_cmd_known(32767, 32767, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000);
        // most positive coefficients everywhere
        add_write(REG_COEF_X1, 16'h7FFF);
        add_write(REG_COEF_Y1, 16'h7FFF);
        add_write(REG_COEF_X2, 16'h7FFF);
        add_write(REG_COEF_Y2, 16'h7FFF);
        add_write(REG_COEF_X3, 16'h7FFF);
        add_write(REG_COEF_Y3, 16'h7FFF);
        add_write(REG_COEF_ROT, 16'h7FFF);
        add_cmd_known(32767, 32767, 32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111);
        add_cmd_known(-32768, 32767, -32768, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000);
        add_write(REG_RELOAD, 12345);
        add_cmd(100, -100, 50);
        add_cmd(-3, 2, 1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
            end
            else
                send_cmd(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].wz,
                         directed_rows[i].has_want, directed_rows[i].want);
        end

        // random phases, a fresh register setting for each
        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
            begin
                // wheels at 0, 120 and 240 degrees
                write_reg(REG_COEF_X1, 2048);
                write_reg(REG_COEF_Y1, 0);
                write_reg(REG_COEF_X2, -1024);
                write_reg(REG_COEF_Y2, 1774);
                write_reg(REG_COEF_X3, -1024);
                write_reg(REG_COEF_Y3, -1774);
                write_reg(REG_COEF_ROT, 512);
                write_reg(REG_RELOAD, 999);
            end
            else
            begin
                write_reg(REG_COEF_X1, rand_coef());
                write_reg(REG_COEF_Y1, rand_coef());
                write_reg(REG_COEF_X2, rand_coef());
                write_reg(REG_COEF_Y2, rand_coef());
                write_reg(REG_COEF_X3, rand_coef());
                write_reg(REG_COEF_Y3, rand_coef());
                write_reg(REG_COEF_ROT, rand_coef());
                write_reg(REG_RELOAD, rand_reload());
            end
            // some phases run back to back on one or both sides
            sender_burst = (p == 2 || p == 5);
            sink_burst   = (p == 3 || p == 5);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 1 && k == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_cmd(rand_vel(), rand_vel(), rand_vel(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
sv/owpm_pkg.sv
sv/omni_wheel_pwm_mixer.sv
dv/tb_omni_wheel_pwm_mixer.sv
